FILE: hw/rtl/xs1024_pkg.sv
// ----------------------------------------------------------------------------
// xs1024_pkg: shared types, constants and mixing functions
// Word and pointer widths, item kinds, the scrambling multiplier and the
// forward and backward xorshift networks of the generator.
// ----------------------------------------------------------------------------
package xs1024_pkg;

    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 16;
    localparam int PTR_W     = 4;
    localparam int HALF_W    = 32;

    localparam int SHIFT_A = 31;
    localparam int SHIFT_B = 11;
    localparam int SHIFT_C = 30;

    localparam logic [WORD_W-1:0] MULT    = 64'd1181783497276652981;
    localparam logic [HALF_W-1:0] MULT_LO = MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MULT_HI = MULT[WORD_W-1:HALF_W];

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PTR_W-1:0]  ptr_t;

    typedef enum logic [1:0] {
        KIND_FWD  = 2'd0,
        KIND_BWD  = 2'd1,
        KIND_LOAD = 2'd2
    } kind_t;

    // One word on its way to the scrambler
    typedef struct packed {
        logic  valid;
        word_t word;
    } word_item_t;

    // Forward step: s0 is the word the pointer leaves, s1 the one it reaches
    function automatic word_t fwd_mix(input word_t s0, input word_t s1);
        word_t t;
        t = s1 ^ (s1 << SHIFT_A);
        return t ^ s0 ^ (t >> SHIFT_B) ^ (s0 >> SHIFT_C);
    endfunction

    // Backward step: recover the overwritten word from the mixed word s1
    // and its predecessor s0
    function automatic word_t bwd_mix(input word_t s1, input word_t s0);
        word_t x;
        x = s1 ^ (s0 >> SHIFT_C) ^ s0;
        x = x ^ (x >> 11);
        x = x ^ (x >> 22);
        x = x ^ (x >> 44);
        x = x ^ (x << 31);
        x = x ^ (x << 62);
        return x;
    endfunction

endpackage

FILE: hw/rtl/xs1024_cmd_if.sv
// ----------------------------------------------------------------------------
// xs1024_cmd_if: command channel
// Valid/ready channel that carries one generator command item.
// ----------------------------------------------------------------------------
interface xs1024_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  seed_index;
    logic [63:0] seed_value;

    modport source (output valid, output kind, output seed_index, output seed_value,
                    input ready);
    modport sink   (input valid, input kind, input seed_index, input seed_value,
                    output ready);
endinterface

FILE: hw/rtl/xs1024_rand_if.sv
// ----------------------------------------------------------------------------
// xs1024_rand_if: random value channel
// Valid/ready channel that carries one scrambled output word.
// ----------------------------------------------------------------------------
interface xs1024_rand_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

FILE: hw/rtl/xs1024_state.sv
// ----------------------------------------------------------------------------
// xs1024_state: generator state and step logic
// Holds the sixteen words rotated so the current word sits at slot 0, applies
// one command per cycle unless stalled and registers the new current word.
// ----------------------------------------------------------------------------
module xs1024_state (
    input  logic                    clk,
    input  logic                    rst_n,
    xs1024_cmd_if.sink              cmd,
    input  logic                    item_ready,
    output xs1024_pkg::word_item_t  item
);
    import xs1024_pkg::*;

    // words_reg[k] holds state word (pointer + k) mod 16
    word_t words_reg  [NUM_WORDS];
    word_t words_next [NUM_WORDS];
    ptr_t  ptr_reg;
    ptr_t  ptr_next;
    logic  valid_reg;
    word_t word_reg;
    logic  cmd_fire;
    kind_t kind;

    assign kind      = kind_t'(cmd.kind);
    assign cmd.ready = !valid_reg || item_ready;
    assign cmd_fire  = cmd.valid && cmd.ready;

    always_comb
    begin
        ptr_t rot_idx;
        rot_idx  = '0;
        ptr_next = ptr_reg;
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            words_next[k] = words_reg[k];
        end
        if (cmd_fire)
        begin
            case (kind)
                KIND_FWD:
                begin
                    ptr_next      = ptr_reg + ptr_t'(1);
                    words_next[0] = fwd_mix(words_reg[0], words_reg[1]);
                    for (int k = 1; k < NUM_WORDS - 1; k++)
                    begin
                        words_next[k] = words_reg[k + 1];
                    end
                    words_next[NUM_WORDS-1] = words_reg[0];
                end
                KIND_BWD:
                begin
                    ptr_next      = ptr_reg - ptr_t'(1);
                    words_next[0] = words_reg[NUM_WORDS-1];
                    words_next[1] = bwd_mix(words_reg[0], words_reg[NUM_WORDS-1]);
                    for (int k = 2; k < NUM_WORDS; k++)
                    begin
                        words_next[k] = words_reg[k - 1];
                    end
                end
                KIND_LOAD:
                begin
                    // Pointer returns to zero: rotate back to absolute order
                    ptr_next = '0;
                    for (int k = 0; k < NUM_WORDS; k++)
                    begin
                        rot_idx       = PTR_W'(k) - ptr_reg;
                        words_next[k] = words_reg[rot_idx];
                    end
                    words_next[cmd.seed_index] = cmd.seed_value;
                end
                default:
                begin
                    ptr_next = ptr_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            valid_reg <= 1'b0;
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                words_reg[k] <= '0;
            end
        end
        else
        begin
            ptr_reg <= ptr_next;
            for (int k = 0; k < NUM_WORDS; k++)
            begin
                words_reg[k] <= words_next[k];
            end
            if (cmd_fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (item_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            word_reg <= words_next[0];
        end
    end

    assign item.valid = valid_reg;
    assign item.word  = word_reg;

    a_fwd_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && kind == KIND_FWD |=> words_reg[NUM_WORDS-1] == $past(words_reg[0]))
        else $error("forward step lost the departing word");

    a_bwd_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && kind == KIND_BWD |=> words_reg[0] == $past(words_reg[NUM_WORDS-1]))
        else $error("backward step did not restore the previous word");

    a_word_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> word_reg == words_reg[0] && valid_reg)
        else $error("registered word differs from current state word");

endmodule

FILE: hw/rtl/xs1024_scramble.sv
// ----------------------------------------------------------------------------
// xs1024_scramble: pipelined multiply by the odd constant
// Three 32x32 partial products in one stage, their sum modulo 2^64 in the
// output register.
// ----------------------------------------------------------------------------
module xs1024_scramble (
    input  logic                    clk,
    input  logic                    rst_n,
    input  xs1024_pkg::word_item_t  item,
    output logic                    item_ready,
    xs1024_rand_if.source           result
);
    import xs1024_pkg::*;

    logic              prod_valid_reg;
    logic              out_valid_reg;
    word_t             pp_ll_reg;
    logic [HALF_W-1:0] pp_lh_reg;
    logic [HALF_W-1:0] pp_hl_reg;
    word_t             out_reg;
    logic              prod_adv;
    logic              out_adv;
    logic [HALF_W-1:0] a_lo;
    logic [HALF_W-1:0] a_hi;
    logic [HALF_W-1:0] cross_sum;

    assign out_adv    = !out_valid_reg || result.ready;
    assign prod_adv   = !prod_valid_reg || out_adv;
    assign item_ready = prod_adv;

    assign a_lo      = item.word[HALF_W-1:0];
    assign a_hi      = item.word[WORD_W-1:HALF_W];
    assign cross_sum = pp_lh_reg + pp_hl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_adv)
            begin
                prod_valid_reg <= item.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_adv && item.valid)
        begin
            pp_ll_reg <= word_t'(a_lo) * word_t'(MULT_LO);
            pp_lh_reg <= a_lo * MULT_HI;
            pp_hl_reg <= a_hi * MULT_LO;
        end
        if (out_adv && prod_valid_reg)
        begin
            out_reg <= pp_ll_reg + {cross_sum, {HALF_W{1'b0}}};
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.random_value = out_reg;

    a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && !out_adv |=> prod_valid_reg && $stable(pp_ll_reg))
        else $error("product stage dropped a stalled item");

    a_prod_take: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && prod_adv |=> prod_valid_reg)
        else $error("product stage missed an incoming item");

    a_out_take: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && out_adv |=> out_valid_reg)
        else $error("output stage missed a product");

endmodule

FILE: hw/rtl/xorshift1024star_reversible_generator.sv
// ----------------------------------------------------------------------------
// xorshift1024star_reversible_generator: reversible xorshift1024* source
// Steps forward, steps backward or loads a seed word per item and returns
// the current word scrambled by the odd multiplier.
// ----------------------------------------------------------------------------
// Pipeline: three register stages (state update at the accepting edge,
//   partial products, final sum). Throughput: one item per cycle while
//   the result channel is not stalled; the state step is a single
//   XOR/shift network into the rotated word register, the 64-bit multiply
//   is split into three 32x32 products over two pipeline stages.
// Reset: rst_n clears all sixteen words and the pointer to zero and empties
//   the pipeline; seed before use, an unseeded generator yields zero.
// ----------------------------------------------------------------------------
module xorshift1024star_reversible_generator (
    input  logic          clk,
    input  logic          rst_n,
    xs1024_cmd_if.sink    cmd,
    xs1024_rand_if.source result
);
    import xs1024_pkg::*;

    // Current word handed from the state stage to the multiplier pipeline
    word_item_t cur_item;
    logic       cur_ready;

    // State stage: the words are kept rotated so that the word under the
    // pointer is always slot 0. A forward step shifts the ring down by one
    // and mixes the new head, a backward step shifts it up and un-mixes the
    // word it leaves behind; a load rotates back to absolute order, since
    // the pointer returns to zero, and writes the seed word.
    xs1024_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item_ready (cur_ready),
        .item       (cur_item)
    );

    // Scrambler: each stage holds one item and advances whenever the stage
    // after it is empty or moving, so a waiting result does not block new
    // commands while any stage behind it is free.
    xs1024_scramble u_scramble (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (cur_item),
        .item_ready (cur_ready),
        .result     (result)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: reversible xorshift1024* generator
// Drives forward, backward, load and unused-kind items over the command
// channel, predicts every scrambled word in step with the accepted items and
// checks each returned word in order, under random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import xs1024_pkg::*;

    // The unused fourth code of the two-bit kind field
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int  NUM_RANDOM_ITEMS = 1850;
    localparam int  DRAIN_CYCLES     = 12;
    localparam int  REPORT_LIMIT     = 10;
    localparam real RUN_LIMIT_NS     = 2_000_000.0;

    typedef struct {
        logic [1:0] kind;
        ptr_t       seed_index;
        word_t      seed_value;
    } gen_cmd_t;

    logic clk = 1'b0;
    logic rst_n;

    xs1024_cmd_if  cmd_ch ();
    xs1024_rand_if rand_ch ();

    xorshift1024star_reversible_generator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (rand_ch)
    );

    // Items waiting to be driven, and scrambled words waiting to come back
    gen_cmd_t pending_cmds[$];
    word_t    expected_words[$];

    // Shadow copy of the generator state
    word_t shadow_words [NUM_WORDS];
    ptr_t  shadow_ptr;

    int  mismatches  = 0;
    int  total_cmds  = 0;
    int  sent_cmds   = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    // Set at the rising edge that takes a command, cleared at the falling edge
    bit  cmd_taken   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic word_t scramble(input word_t w);
        return w * MULT;
    endfunction

    // Advance the pointer and fold the word it left into the one it reached
    function automatic void shadow_forward();
        word_t s0;
        word_t s1;
        s0 = shadow_words[shadow_ptr];
        shadow_ptr = shadow_ptr + ptr_t'(1);
        s1 = shadow_words[shadow_ptr];
        s1 = s1 ^ (s1 << SHIFT_A);
        shadow_words[shadow_ptr] = s1 ^ s0 ^ (s1 >> SHIFT_B) ^ (s0 >> SHIFT_C);
    endfunction

    // Undo one forward step: strip the s0 terms, then solve the two
    // xorshifts by fixed-point iteration (each pass settles one more shift
    // width of bits)
    function automatic void shadow_backward();
        word_t mixed;
        word_t s0;
        word_t x;
        word_t y;
        word_t z;
        mixed = shadow_words[shadow_ptr];
        shadow_ptr = shadow_ptr - ptr_t'(1);
        s0 = shadow_words[shadow_ptr];
        x = mixed ^ s0 ^ (s0 >> SHIFT_C);
        y = x;
        for (int i = 0; i < 6; i++)
            y = x ^ (y >> SHIFT_B);
        z = y;
        for (int i = 0; i < 3; i++)
            z = y ^ (z << SHIFT_A);
        shadow_words[shadow_ptr + ptr_t'(1)] = z;
    endfunction

    function automatic void shadow_apply(input gen_cmd_t c);
        case (c.kind)
            KIND_FWD:  shadow_forward();
            KIND_BWD:  shadow_backward();
            KIND_LOAD:
            begin
                shadow_words[c.seed_index] = c.seed_value;
                shadow_ptr = '0;
            end
            default: ;  // unused kind leaves the state alone
        endcase
        expected_words.push_back(scramble(shadow_words[shadow_ptr]));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic word_t rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void queue_cmd(input logic [1:0] kind, input ptr_t idx,
                                      input word_t val);
        gen_cmd_t c;
        c.kind       = kind;
        c.seed_index = idx;
        c.seed_value = val;
        pending_cmds.push_back(c);
    endfunction

    // Steps carry random junk in the seed fields, which the block must ignore
    function automatic void queue_step(input logic [1:0] kind);
        queue_cmd(kind, ptr_t'($urandom_range(NUM_WORDS - 1)), rand_word());
    endfunction

    // Seed values: mostly dense, now and then a single bit or an extreme
    function automatic word_t rand_seed();
        case ($urandom_range(9))
            0:       return word_t'(1) << $urandom_range(WORD_W - 1);
            1:       return '1;
            2:       return '0;
            default: return rand_word();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : build_stimulus
        int steps_done;
        int run_len;
        int fwd_bias;
        int order [NUM_WORDS];
        int j;
        int tmp;

        // Unseeded state: every step yields zero, backward steps included,
        // and a backward step from reset wraps the pointer below zero
        queue_step(KIND_FWD);
        queue_step(KIND_BWD);
        queue_step(KIND_BWD);
        queue_step(KIND_UNUSED);
        queue_step(KIND_FWD);

        // Extreme seeds at the extreme indexes
        queue_cmd(KIND_LOAD, 4'd0, '1);
        queue_cmd(KIND_LOAD, 4'd15, '1);
        queue_cmd(KIND_LOAD, 4'd1, 64'h8000_0000_0000_0001);
        queue_cmd(KIND_LOAD, 4'd14, 64'h0000_0000_0000_0000);
        queue_step(KIND_FWD);
        queue_step(KIND_FWD);
        queue_step(KIND_UNUSED);
        queue_step(KIND_BWD);
        queue_step(KIND_BWD);
        // Backward across the wrap from word 0 to word 15
        queue_step(KIND_BWD);
        queue_step(KIND_BWD);
        queue_step(KIND_FWD);
        queue_step(KIND_FWD);
        queue_cmd(KIND_LOAD, 4'd2, 64'hFFFF_FFFF_0000_0000);
        queue_cmd(KIND_LOAD, 4'd0, '0);
        queue_step(KIND_FWD);
        queue_step(KIND_FWD);
        queue_step(KIND_BWD);
        queue_step(KIND_UNUSED);

        // Random part: in most rounds fully seed the state in a shuffled order,
        // then run a stretch of steps that leans forwards or backwards, with a
        // little noise from unused kinds and stray loads
        steps_done = 0;
        while (steps_done < NUM_RANDOM_ITEMS)
        begin
            if ($urandom_range(3) != 0)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                    order[i] = i;
                for (int i = NUM_WORDS - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < NUM_WORDS; i++)
                    queue_cmd(KIND_LOAD, ptr_t'(order[i]), rand_seed());
                steps_done += NUM_WORDS;
            end
            run_len  = $urandom_range(60, 10);
            fwd_bias = $urandom_range(90, 30);
            for (int i = 0; i < run_len; i++)
            begin
                tmp = $urandom_range(99);
                if (tmp < 4)
                    queue_step(KIND_UNUSED);
                else
                begin
                    if (tmp < 7)
                        queue_cmd(KIND_LOAD, ptr_t'($urandom_range(NUM_WORDS - 1)),
                                  rand_seed());
                    else if ($urandom_range(99) < fwd_bias)
                        queue_step(KIND_FWD);
                    else
                        queue_step(KIND_BWD);
                    steps_done++;
                end
            end
        end
        total_cmds = pending_cmds.size();
    end

    // ------------------------------------------------------------------
    // Reset, end of run
    // ------------------------------------------------------------------

    initial
    begin
        // Hold every input at a known value from time zero
        cmd_ch.valid      = 1'b0;
        cmd_ch.kind       = KIND_FWD;
        cmd_ch.seed_index = '0;
        cmd_ch.seed_value = '0;
        rand_ch.ready     = 1'b0;
        for (int i = 0; i < NUM_WORDS; i++)
            shadow_words[i] = '0;
        shadow_ptr = '0;

        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Wait until every item has gone in and every word has come back
        @(posedge clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_words.size() != 0)
            @(posedge clk);
        // Give the pipeline time to show any stray extra word
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: change inputs at the falling edge
    // ------------------------------------------------------------------

    // Idling pattern: sender light and receiver heavy, then swapped, then none
    always_comb
    begin
        if (sent_cmds < total_cmds / 3)
        begin
            send_idle_pct  = 16;
            recv_stall_pct = 46;
        end
        else if (sent_cmds < (2 * total_cmds) / 3)
        begin
            send_idle_pct  = 46;
            recv_stall_pct = 16;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    end

    always @(negedge clk)
    begin : drive_cmds
        gen_cmd_t next_cmd;
        if (rst_n)
        begin
            // Hold the current item until it has been taken
            if (!cmd_ch.valid || cmd_taken)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_cmd = pending_cmds.pop_front();
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.kind       <= next_cmd.kind;
                    cmd_ch.seed_index <= next_cmd.seed_index;
                    cmd_ch.seed_value <= next_cmd.seed_value;
                    sent_cmds++;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
            rand_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
        cmd_taken = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : watch_channels
        gen_cmd_t taken;
        word_t    want;
        if (rst_n)
        begin
            // Predict first, so even a word returned at the accepting edge would find its match
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                taken.kind       = cmd_ch.kind;
                taken.seed_index = cmd_ch.seed_index;
                taken.seed_value = cmd_ch.seed_value;
                shadow_apply(taken);
                cmd_taken = 1'b1;
            end
            if (rand_ch.valid && rand_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected word %h", $realtime,
                                 rand_ch.random_value);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rand_ch.random_value !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: random_value expected %h actual %h",
                                     $realtime, want, rand_ch.random_value);
                    end
                end
            end
        end
    end

endmodule

FILE: files.f
hw/rtl/xs1024_pkg.sv
hw/rtl/xs1024_cmd_if.sv
hw/rtl/xs1024_rand_if.sv
hw/rtl/xs1024_state.sv
hw/rtl/xs1024_scramble.sv
hw/rtl/xorshift1024star_reversible_generator.sv
tb/testbench.sv
